// File: hdl/lnp_pkg.sv
package lnp_pkg;

	localparam int MAX_SLOTS = 64;
	localparam int FRAC_BITS = 15;

	localparam int SLOT_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
	localparam int TAU_W    = 31;
	localparam int REFR_W   = 16;
	// Magnitude of (rest - v) scaled by 2^FRAC_BITS.
	localparam int DVD_W    = 33 + FRAC_BITS;
	localparam int DIVCNT_W = $clog2(DVD_W + 1);
	localparam int SUM_W    = DVD_W + 3;

	typedef enum logic [1:0] {
		K_BIRTH = 2'd0,
		K_DEATH = 2'd1,
		K_ADD   = 2'd2,
		K_TICK  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		RK_BORN  = 3'd0,
		RK_FULL  = 3'd1,
		RK_DIED  = 3'd2,
		RK_MISS  = 3'd3,
		RK_SPIKE = 3'd4
	} rkind_t;

	typedef enum logic [2:0] {
		CFG_THR  = 3'd0,
		CFG_RST  = 3'd1,
		CFG_REST = 3'd2,
		CFG_BIAS = 3'd3,
		CFG_TAU  = 3'd4,
		CFG_REFR = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0]        id;
		logic signed [31:0] v;
		logic [REFR_W-1:0]  refr;
		logic signed [31:0] acc;
		logic [31:0]        spk;
		logic [31:0]        lft;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_BIRTH,
		S_WALK_RD,
		S_WALK_CHK,
		S_DEATH_END,
		S_TICK_RD,
		S_TICK_CHK,
		S_DIV,
		S_UPD,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic latch;
		logic birth;
		logic chk_find;
		logic remove;
		logic emit;
		logic tick_ref;
		logic div_start;
		logic tick_upd;
		logic flush;
		logic rot;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  full;
		logic  walk_done;
		logic  refr_nz;
		logic  tau_zero;
		logic  div_busy;
		logic  fire;
		logic  pend_valid;
		logic  out_free;
		logic  found;
	} sts_t;

endpackage

// File: hdl/lnp_ram.sv
module lnp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/lnp_div.sv
module lnp_div
	import lnp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [TAU_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quot
);

	// Restoring division, one quotient bit per cycle.
	logic [TAU_W:0]    rem_q;
	logic [DVD_W-1:0]  quot_q;
	logic [TAU_W-1:0]  dsr_q;
	logic [DIVCNT_W-1:0] cnt_q;
	logic [TAU_W:0]    rem_sh;
	logic [TAU_W+1:0]  trial;

	assign rem_sh = {rem_q[TAU_W-1:0], quot_q[DVD_W-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, dsr_q};
	assign busy   = (cnt_q != '0);
	assign quot   = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIVCNT_W'(DVD_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			dsr_q  <= divisor;
		end else if (busy) begin
			if (!trial[TAU_W+1]) begin
				rem_q  <= trial[TAU_W:0];
				quot_q <= {quot_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				quot_q <= {quot_q[DVD_W-2:0], 1'b0};
			end
		end
	end

endmodule

// File: hdl/lnp_dp.sv
module lnp_dp
	import lnp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [1:0]  kind,
	input  logic [31:0] nrn_id,
	input  logic [31:0] weight,
	input  logic [31:0] timestep,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [2:0]  result_kind,
	output logic [31:0] neuron_id_res,
	output logic [31:0] fire_total,
	output logic        is_last
);

	// Configuration.
	logic signed [31:0] thr_q, rst_q, rest_q, bias_q;
	logic [TAU_W-1:0]   tau_q;
	logic [REFR_W-1:0]  refr_cfg_q;

	// Latched item.
	kind_t              kind_q;
	logic [31:0]        id_q;
	logic signed [31:0] weight_q;
	logic [31:0]        ts_q;

	// Pool bookkeeping.
	logic [MAX_SLOTS-1:0] valid_q;
	logic [SLOT_W-1:0]    ord_q  [MAX_SLOTS];
	logic [SLOT_W-1:0]    ord_up [MAX_SLOTS];
	logic [SLOT_W-1:0]    ord_dn [MAX_SLOTS];
	logic [CNT_W-1:0]     live_q;
	logic [CNT_W-1:0]     pos_q;
	logic                 found_q;
	logic [CNT_W-1:0]     fpos_q;
	logic [SLOT_W-1:0]    fslot_q;
	logic [SLOT_W-1:0]    free_slot;
	logic [SLOT_W-1:0]    head;

	// Slot memory.
	logic               we;
	logic [SLOT_W-1:0]  waddr;
	entry_t             wdata, rdata, ent_q;
	logic [ENTRY_W-1:0] rd_raw;
	logic               match;

	// Tick arithmetic.
	logic                    div_busy;
	logic                    div_go;
	logic [DVD_W-1:0]        quot;
	logic signed [32:0]      diff;
	logic signed [DVD_W-1:0] dvd;
	logic [DVD_W-1:0]        mag;
	logic                    neg_q;
	logic signed [DVD_W:0]   leak;
	logic signed [SUM_W-1:0] sum;
	logic signed [31:0]      nv;
	logic                    fire;
	logic signed [32:0]      acc_sum;
	logic signed [31:0]      acc_new;

	// Result staging.
	logic        pend_valid_q;
	logic [31:0] pend_id_q, pend_tot_q;
	logic        o_valid_q;
	rkind_t      o_kind_q;
	logic [31:0] o_id_q, o_tot_q;
	logic        o_last_q;
	logic        out_free;
	rkind_t      emit_kind;

	assign head   = ord_q[0];
	assign rdata  = entry_t'(rd_raw);
	assign match  = (rdata.id == id_q) && !found_q;
	assign out_free = !o_valid_q || !out_stall;

	// With no leak term the divider is left idle.
	assign div_go = cmd.div_start && (tau_q != '0);

	lnp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (head),
		.rdata (rd_raw)
	);

	lnp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (mag),
		.divisor  (tau_q),
		.busy     (div_busy),
		.quot     (quot)
	);

	always_comb begin
		free_slot = '0;
		for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_SLOTS - 1; i++) begin
			ord_up[i] = ord_q[i + 1];
		end
		ord_up[MAX_SLOTS - 1] = ord_q[MAX_SLOTS - 1];
		ord_dn[0] = free_slot;
		for (int i = 1; i < MAX_SLOTS; i++) begin
			ord_dn[i] = ord_q[i - 1];
		end
	end

	// Leak dividend: (rest - v) * 2^FRAC_BITS, divided as a magnitude.
	assign diff = {rest_q[31], rest_q} - {rdata.v[31], rdata.v};
	assign dvd  = DVD_W'(diff) <<< FRAC_BITS;
	assign mag  = diff[32] ? (~dvd + 1'b1) : dvd;

	always_comb begin
		if (tau_q == '0) begin
			leak = '0;
		end else if (neg_q) begin
			leak = -$signed({1'b0, quot});
		end else begin
			leak = $signed({1'b0, quot});
		end
	end

	assign sum = SUM_W'(ent_q.v) + SUM_W'(leak) + SUM_W'(bias_q) + SUM_W'(ent_q.acc);

	always_comb begin
		if (sum[SUM_W-1:31] == '0 || sum[SUM_W-1:31] == '1) begin
			nv = sum[31:0];
		end else if (sum[SUM_W-1]) begin
			nv = 32'sh8000_0000;
		end else begin
			nv = 32'sh7fff_ffff;
		end
	end

	assign fire = (nv >= thr_q);

	assign acc_sum = {rdata.acc[31], rdata.acc} + {weight_q[31], weight_q};
	assign acc_new = (acc_sum[32] == acc_sum[31]) ? acc_sum[31:0] :
		(acc_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff);

	always_comb begin
		we    = 1'b0;
		waddr = head;
		wdata = rdata;
		if (cmd.birth) begin
			we    = 1'b1;
			waddr = free_slot;
			wdata = '{id: id_q, v: rest_q, refr: '0, acc: '0, spk: '0, lft: '0};
		end else if (cmd.chk_find && match && kind_q == K_ADD) begin
			we        = 1'b1;
			wdata.acc = acc_new;
		end else if (cmd.tick_ref) begin
			we         = 1'b1;
			wdata.refr = rdata.refr - 1'b1;
			wdata.v    = rst_q;
			wdata.acc  = '0;
		end else if (cmd.tick_upd) begin
			we        = 1'b1;
			wdata     = ent_q;
			wdata.acc = '0;
			if (fire) begin
				wdata.v    = rst_q;
				wdata.refr = refr_cfg_q;
				wdata.spk  = ent_q.spk + 1'b1;
				wdata.lft  = ts_q;
			end else begin
				wdata.v = nv;
			end
		end
	end

	always_comb begin
		if (kind_q == K_BIRTH) begin
			emit_kind = (live_q == CNT_W'(MAX_SLOTS)) ? RK_FULL : RK_BORN;
		end else begin
			emit_kind = found_q ? RK_DIED : RK_MISS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= -32'sd1638400;
			rst_q      <= -32'sd2129920;
			rest_q     <= -32'sd2129920;
			bias_q     <= '0;
			tau_q      <= TAU_W'(655360);
			refr_cfg_q <= REFR_W'(2);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_THR:  thr_q      <= cfg_data;
				CFG_RST:  rst_q      <= cfg_data;
				CFG_REST: rest_q     <= cfg_data;
				CFG_BIAS: bias_q     <= cfg_data;
				CFG_TAU:  tau_q      <= cfg_data[TAU_W-1:0];
				CFG_REFR: refr_cfg_q <= cfg_data[REFR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q   <= kind_t'(kind);
			id_q     <= nrn_id;
			weight_q <= weight;
			ts_q     <= timestep;
		end
		if (cmd.chk_find && match) begin
			fpos_q  <= pos_q;
			fslot_q <= head;
		end
		if (cmd.tick_ref || cmd.div_start) begin
			ent_q <= rdata;
		end
		if (cmd.div_start) begin
			neg_q <= diff[32];
		end
		if (cmd.rot) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				if (i + 1 < int'(live_q)) begin
					ord_q[i] <= ord_up[i];
				end else if (i + 1 == int'(live_q)) begin
					ord_q[i] <= ord_q[0];
				end
			end
		end else if (cmd.birth) begin
			ord_q <= ord_dn;
		end else if (cmd.remove) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				if (i >= int'(fpos_q)) begin
					ord_q[i] <= ord_up[i];
				end
			end
		end
		if (cmd.tick_upd && fire) begin
			pend_id_q  <= ent_q.id;
			pend_tot_q <= ent_q.spk + 1'b1;
		end
		if (cmd.emit) begin
			o_kind_q <= emit_kind;
			o_id_q   <= id_q;
			o_tot_q  <= '0;
			o_last_q <= 1'b1;
		end else if (cmd.tick_upd && fire && pend_valid_q) begin
			o_kind_q <= RK_SPIKE;
			o_id_q   <= pend_id_q;
			o_tot_q  <= pend_tot_q;
			o_last_q <= 1'b0;
		end else if (cmd.flush) begin
			o_kind_q <= RK_SPIKE;
			o_id_q   <= pend_id_q;
			o_tot_q  <= pend_tot_q;
			o_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			live_q       <= '0;
			pos_q        <= '0;
			found_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			o_valid_q    <= 1'b0;
		end else begin
			if (cmd.latch) begin
				pos_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.rot) begin
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.chk_find && match) begin
				found_q <= 1'b1;
			end
			if (cmd.birth) begin
				valid_q[free_slot] <= 1'b1;
				live_q             <= live_q + 1'b1;
			end else if (cmd.remove) begin
				valid_q[fslot_q] <= 1'b0;
				live_q           <= live_q - 1'b1;
			end
			if (cmd.tick_upd && fire) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.emit || cmd.flush || (cmd.tick_upd && fire && pend_valid_q)) begin
				o_valid_q <= 1'b1;
			end else if (!out_stall) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	assign sts.kind       = kind_q;
	assign sts.full       = (live_q == CNT_W'(MAX_SLOTS));
	assign sts.walk_done  = (pos_q == live_q);
	assign sts.refr_nz    = (rdata.refr != '0);
	assign sts.tau_zero   = (tau_q == '0);
	assign sts.div_busy   = div_busy;
	assign sts.fire       = fire;
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = out_free;
	assign sts.found      = found_q;

	assign out_valid     = o_valid_q;
	assign result_kind   = o_kind_q;
	assign neuron_id_res = o_id_q;
	assign fire_total    = o_tot_q;
	assign is_last       = o_last_q;

endmodule

// File: hdl/lnp_ctrl.sv
module lnp_ctrl
	import lnp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] kind,
	output logic       in_stall,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch = 1'b1;
					case (kind_t'(kind))
						K_BIRTH: state_d = S_BIRTH;
						K_TICK:  state_d = S_TICK_RD;
						default: state_d = S_WALK_RD;
					endcase
				end
			end
			S_BIRTH: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					cmd.birth = !sts.full;
					state_d   = S_IDLE;
				end
			end
			S_WALK_RD: begin
				if (sts.walk_done) begin
					state_d = (sts.kind == K_DEATH) ? S_DEATH_END : S_IDLE;
				end else begin
					state_d = S_WALK_CHK;
				end
			end
			S_WALK_CHK: begin
				cmd.chk_find = 1'b1;
				cmd.rot      = 1'b1;
				state_d      = S_WALK_RD;
			end
			S_DEATH_END: begin
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.remove = sts.found;
					state_d    = S_IDLE;
				end
			end
			S_TICK_RD: begin
				state_d = sts.walk_done ? S_FLUSH : S_TICK_CHK;
			end
			S_TICK_CHK: begin
				if (sts.refr_nz) begin
					cmd.tick_ref = 1'b1;
					cmd.rot      = 1'b1;
					state_d      = S_TICK_RD;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = sts.tau_zero ? S_UPD : S_DIV;
				end
			end
			S_DIV: begin
				if (!sts.div_busy) begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				if (!(sts.fire && sts.pend_valid) || sts.out_free) begin
					cmd.tick_upd = 1'b1;
					cmd.rot      = 1'b1;
					state_d      = S_TICK_RD;
				end
			end
			S_FLUSH: begin
				if (!sts.pend_valid) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: hdl/lif_neuron_pool_unit.sv
// Birth: the result is loaded from the birth state once the output stage is free. Death and
// add input: one lookup walk over the slot memory for the N live neurons. Tick: per neuron,
// refractory neurons skip the update, and the bit-serial leak divider is skipped when tau is zero.
// One item is in work at a time; a new item is taken only when the previous one is done.
// Reset clears the pool, the state machine and the output stage and loads the register
// defaults; the slot memory needs no clearing pass.
module lif_neuron_pool_unit
	import lnp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] nrn_id,
	input  logic [31:0] weight,
	input  logic [31:0] timestep,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_kind,
	output logic [31:0] neuron_id_res,
	output logic [31:0] fire_total,
	output logic        is_last
);

	// The controller sequences each transaction; the datapath holds the slot memory,
	// the age-ordered slot list, the divider and the result stage.
	cmd_t cmd;
	sts_t sts;

	lnp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The slot list keeps live slots newest first, so a lookup or a tick walks it by
	// rotating the list once around, which leaves it in its original order.
	lnp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (kind),
		.nrn_id        (nrn_id),
		.weight        (weight),
		.timestep      (timestep),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.result_kind   (result_kind),
		.neuron_id_res (neuron_id_res),
		.fire_total    (fire_total),
		.is_last       (is_last)
	);

	// A birth must never be committed into a full pool.
	a_no_birth_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.birth |-> !sts.full)
		else $error("birth committed into a full pool");

	// The result stage is loaded only when it is free to take a new transaction.
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.flush) |-> sts.out_free)
		else $error("result stage overwritten");

	// The slot list is changed by at most one operation per cycle.
	a_list_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.rot, cmd.birth, cmd.remove}))
		else $error("conflicting slot list updates");

	// The divider is started only when idle.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider restarted while busy");

endmodule
